@@ design/hsvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared widths, reference color table and candidate type for the HSV
// nearest color classifier.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    // field widths
    localparam int unsigned HUE_W  = 17;
    localparam int unsigned SV_W   = 9;
    localparam int unsigned IDX_W  = 4;
    // wrapped hue difference never exceeds half the circle (46080)
    localparam int unsigned HDIF_W = 16;
    // largest distance is below 2^31, so all ones never wins
    localparam int unsigned DIST_W = 31;

    // full hue circle, 360 degrees in Q8
    localparam logic [HUE_W-1:0] HUE_FULL_Q8 = 17'd92160;

    // number of colors in the table and number of comparator slots
    localparam int unsigned DEFINED_COLORS = 11;
    localparam int unsigned SLOTS          = 16;
    localparam int unsigned NUM_COLORS_DEF = 11;

    // distance used for slots that hold no color
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // one candidate in the minimum search
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    // reference hue per color
    function automatic logic [HUE_W-1:0] ref_hue(input int unsigned k);
        logic [HUE_W-1:0] h;
        case (k)
            1:       h = 17'd30720;  // green
            2:       h = 17'd61440;  // blue
            3:       h = 17'd15360;  // yellow
            7:       h = 17'd9984;   // orange
            8:       h = 17'd89600;  // pink
            10:      h = 17'd76800;  // purple
            default: h = 17'd0;
        endcase
        return h;
    endfunction

    // reference saturation per color
    function automatic logic [SV_W-1:0] ref_sat(input int unsigned k);
        logic [SV_W-1:0] s;
        case (k)
            0, 1, 2, 3, 7, 10: s = 9'd256;
            8:                 s = 9'd64;
            9:                 s = 9'd192;
            default:           s = 9'd0;
        endcase
        return s;
    endfunction

    // reference value per color
    function automatic logic [SV_W-1:0] ref_val(input int unsigned k);
        logic [SV_W-1:0] v;
        case (k)
            0, 1, 2, 3, 5, 7, 8: v = 9'd256;
            6, 10:               v = 9'd128;
            9:                   v = 9'd166;
            default:             v = 9'd0;
        endcase
        return v;
    endfunction

    // pick the lower distance, earlier candidate on a tie
    function automatic t_cand pick_min(input t_cand a, input t_cand b);
        return (b.sq_dist < a.sq_dist) ? b : a;
    endfunction

endpackage

@@ design/hsv_nearest_color_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_nearest_color_classifier_core
// Classifies one HSV sample as the nearest of up to eleven reference colors.
// ----------------------------------------------------------------------------
// A sample is taken in any cycle with start high; busy is always low, so
// a new transaction can start every cycle. Each transaction gives exactly one
// o_valid strobe with o_color_index after it has passed, in order, the input
// register, distance lanes, first half of the minimum tree and result register.
// The result is shown for a single cycle only and the receiver cannot
// stall it; capture it when o_valid is high. Hue above 360 degrees is
// clamped to 360; on equal distances the lower color index wins.
// ----------------------------------------------------------------------------
module hsv_nearest_color_classifier_core #(
    parameter int unsigned NUM_COLORS = hsvc_pkg::NUM_COLORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hsvc_pkg::HUE_W-1:0]  i_hue_q8,
    input  logic [hsvc_pkg::SV_W-1:0]   i_sat_q8,
    input  logic [hsvc_pkg::SV_W-1:0]   i_val_q8,
    output logic                        o_valid,
    output logic [hsvc_pkg::IDX_W-1:0]  o_color_index
);
    import hsvc_pkg::*;

    // colors actually searched
    localparam int unsigned ACTIVE =
        (NUM_COLORS < 1) ? 1 :
        ((NUM_COLORS < DEFINED_COLORS) ? NUM_COLORS : DEFINED_COLORS);
    localparam int unsigned LAT = 4;

    logic [HUE_W-1:0] r_hue;
    logic [SV_W-1:0]  r_sat;
    logic [SV_W-1:0]  r_val;
    logic [HUE_W-1:0] n_hue;
    logic [LAT-1:0]   r_vld;
    logic             accept;
    t_cand            cand [SLOTS];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // input register, hue clamped to the full circle
    assign n_hue = (i_hue_q8 > HUE_FULL_Q8) ? HUE_FULL_Q8 : i_hue_q8;

    always_ff @(posedge i_clk) begin
        r_hue <= n_hue;
        r_sat <= i_sat_q8;
        r_val <= i_val_q8;
    end

    // transaction valid follows the data through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // one distance lane per searched color, idle slots never win
    for (genvar k = 0; k < SLOTS; k++) begin : g_lane
        if (k < ACTIVE) begin : g_used
            hsvc_dist_lane #(
                .K (k)
            ) u_lane (
                .i_clk    (i_clk),
                .i_hue_q8 (r_hue),
                .i_sat_q8 (r_sat),
                .i_val_q8 (r_val),
                .o_cand   (cand[k])
            );
        end else begin : g_idle
            assign cand[k].sq_dist = DIST_MAX;
            assign cand[k].idx     = IDX_W'(k);
        end
    end

    // minimum search
    hsvc_min_tree u_tree (
        .i_clk         (i_clk),
        .i_cand        (cand),
        .o_color_index (o_color_index)
    );

    assign o_valid = r_vld[LAT-1];

    // each started transaction gives exactly one result strobe, and no other strobe
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) &&
         $past(i_rst_n, 4)) |-> (o_valid == $past(start, 4)))
        else $error("result strobe does not match accepted transaction");

    // reported color is one that is searched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_color_index} < (IDX_W+1)'(ACTIVE)))
        else $error("color index outside searched range");

endmodule

@@ design/hsvc_dist_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_dist_lane
// Squared distance from the sample to one reference color, with the hue
// difference wrapped around the circle; result is registered.
// ----------------------------------------------------------------------------
module hsvc_dist_lane #(
    parameter int unsigned K = 0
) (
    input  logic                          i_clk,
    input  logic [hsvc_pkg::HUE_W-1:0]    i_hue_q8,
    input  logic [hsvc_pkg::SV_W-1:0]     i_sat_q8,
    input  logic [hsvc_pkg::SV_W-1:0]     i_val_q8,
    output hsvc_pkg::t_cand               o_cand
);
    import hsvc_pkg::*;

    localparam logic [HUE_W-1:0] REF_H = ref_hue(K);
    localparam logic [SV_W-1:0]  REF_S = ref_sat(K);
    localparam logic [SV_W-1:0]  REF_V = ref_val(K);
    localparam logic [IDX_W-1:0] REF_I = IDX_W'(K);

    logic [HUE_W-1:0]    dh_raw;
    logic [HUE_W-1:0]    dh_wrap;
    logic [HDIF_W-1:0]   dh;
    logic [SV_W-1:0]     ds;
    logic [SV_W-1:0]     dv;
    logic [2*HDIF_W-1:0] hsq;
    logic [2*SV_W-1:0]   ssq;
    logic [2*SV_W-1:0]   vsq;
    logic [DIST_W:0]     sum;
    t_cand               n_cand;
    t_cand               r_cand;

    // absolute differences, hue taken the short way round
    always_comb begin
        dh_raw  = (i_hue_q8 >= REF_H) ? (i_hue_q8 - REF_H) : (REF_H - i_hue_q8);
        dh_wrap = HUE_FULL_Q8 - dh_raw;
        dh      = (dh_wrap < dh_raw) ? dh_wrap[HDIF_W-1:0] : dh_raw[HDIF_W-1:0];
        ds      = (i_sat_q8 >= REF_S) ? (i_sat_q8 - REF_S) : (REF_S - i_sat_q8);
        dv      = (i_val_q8 >= REF_V) ? (i_val_q8 - REF_V) : (REF_V - i_val_q8);
    end

    // squares and their sum
    always_comb begin
        hsq = dh * dh;
        ssq = ds * ds;
        vsq = dv * dv;
        sum = (DIST_W+1)'(hsq)
            + {{(DIST_W+1-2*SV_W){1'b0}}, ssq}
            + {{(DIST_W+1-2*SV_W){1'b0}}, vsq};
        n_cand.sq_dist = sum[DIST_W-1:0];
        n_cand.idx     = REF_I;
    end

    // distance register
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

endmodule

@@ design/hsvc_min_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_min_tree
// Registered minimum search over the candidate slots; the lower index wins
// when distances are equal.
// ----------------------------------------------------------------------------
module hsvc_min_tree (
    input  logic                      i_clk,
    input  hsvc_pkg::t_cand           i_cand [hsvc_pkg::SLOTS],
    output logic [hsvc_pkg::IDX_W-1:0] o_color_index
);
    import hsvc_pkg::*;

    localparam int unsigned L1 = SLOTS / 2;
    localparam int unsigned L2 = SLOTS / 4;

    t_cand lvl1 [L1];
    t_cand n_mid [L2];
    t_cand r_mid [L2];
    t_cand lvl3 [2];
    t_cand n_best;
    logic [IDX_W-1:0] r_idx;

    // first two levels: sixteen down to four
    always_comb begin
        for (int i = 0; i < L1; i++) begin
            lvl1[i] = pick_min(i_cand[2*i], i_cand[2*i+1]);
        end
        for (int i = 0; i < L2; i++) begin
            n_mid[i] = pick_min(lvl1[2*i], lvl1[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    // last two levels: four down to one
    always_comb begin
        lvl3[0] = pick_min(r_mid[0], r_mid[1]);
        lvl3[1] = pick_min(r_mid[2], r_mid[3]);
        n_best  = pick_min(lvl3[0], lvl3[1]);
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_idx <= n_best.idx;
    end

    assign o_color_index = r_idx;

endmodule
